// ===== src/nfid_pkg.sv =====
// Package for the next-fit identifier allocator.
// Holds map geometry, command and status codes, the map request struct
// and the lowest-free-bit search. No dependencies.
package nfid_pkg;

    localparam int NUM_IDS   = 4096;
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = NUM_IDS / WORD_W;
    localparam int SLOT_W    = $clog2(NUM_IDS);
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int CNT_W     = $clog2(NUM_WORDS + 1) + 1;
    localparam int ID_W      = 16;
    localparam int STAT_W    = 3;
    localparam int CMD_W     = 2;

    localparam logic [ID_W-1:0] BASE_RESET = 16'd300;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    localparam logic [STAT_W-1:0] ST_ALLOCATED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_RELEASED     = 3'd1;
    localparam logic [STAT_W-1:0] ST_CLEARED      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NONE_FREE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_IN_USE   = 3'd4;
    localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 3'd5;

    typedef struct packed {
        logic               clr;
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } t_map_req;

    function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== src/nfid_map.sv =====
// Used-bit map: word-wide synchronous memory with per-word valid bits.
// A word never written since the last clear reads as all free.
// Depends on nfid_pkg.
module nfid_map (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  nfid_pkg::t_map_req                      i_req,
    output logic [nfid_pkg::WORD_W-1:0]             o_rd_data
);

    logic [nfid_pkg::WORD_W-1:0]    r_mem [nfid_pkg::NUM_WORDS];
    logic [nfid_pkg::NUM_WORDS-1:0] r_valid;
    logic [nfid_pkg::WORD_W-1:0]    r_rd_word;
    logic                           r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_word <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_word : '0;

endmodule

// ===== src/nfid_ctrl.sv =====
// Command sequencer: next-fit word scan, release read-modify-write,
// clear, and the output word register. Depends on nfid_pkg.
module nfid_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [nfid_pkg::ID_W-1:0]         i_rel_id,
    input  logic [nfid_pkg::CMD_W-1:0]        i_cmd,
    input  logic                              i_cfg_we,
    input  logic [nfid_pkg::ID_W-1:0]         i_cfg_wdata,
    output nfid_pkg::t_map_req                o_map_req,
    input  logic [nfid_pkg::WORD_W-1:0]       i_rd_data,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [nfid_pkg::ID_W-1:0]         o_granted_id,
    output logic [nfid_pkg::STAT_W-1:0]       o_status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_RCHK = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                          r_state;
    logic [nfid_pkg::CMD_W-1:0]          r_cmd;
    logic [nfid_pkg::ID_W-1:0]           r_base;
    logic [nfid_pkg::SLOT_W-1:0]         r_last;
    logic [nfid_pkg::SLOT_W-1:0]         r_slot;
    logic [nfid_pkg::BIT_W-1:0]          r_start_bit;
    logic [nfid_pkg::WADDR_W-1:0]        r_rd_addr;
    logic [nfid_pkg::WADDR_W-1:0]        r_ex_addr;
    logic [nfid_pkg::CNT_W-1:0]          r_rd_cnt;
    logic [nfid_pkg::CNT_W-1:0]          r_ex_cnt;
    logic                                r_pend;
    logic [nfid_pkg::WORD_W-1:0]         r_wdata;
    logic [nfid_pkg::ID_W-1:0]           r_res_id;
    logic [nfid_pkg::STAT_W-1:0]         r_res_status;
    logic                                r_o_valid;
    logic [nfid_pkg::ID_W-1:0]           r_o_id;
    logic [nfid_pkg::STAT_W-1:0]         r_o_status;

    logic                                accept;
    logic [nfid_pkg::SLOT_W-1:0]         n_start;
    logic [nfid_pkg::ID_W-1:0]           rel_off;
    logic [nfid_pkg::WORD_W-1:0]         scan_mask;
    logic [nfid_pkg::WORD_W-1:0]         free_bits;
    logic [nfid_pkg::BIT_W-1:0]          free_idx;
    logic [nfid_pkg::WORD_W-1:0]         slot_bit;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign n_start         = r_last + nfid_pkg::SLOT_W'(1);
    assign rel_off         = i_rel_id - r_base;

    // first word: bits from the start bit up; last (wrapped) word: bits below it
    always_comb begin
        if (r_ex_cnt == '0) begin
            scan_mask = {nfid_pkg::WORD_W{1'b1}} << r_start_bit;
        end else if (r_ex_cnt == nfid_pkg::CNT_W'(nfid_pkg::NUM_WORDS)) begin
            scan_mask = ~({nfid_pkg::WORD_W{1'b1}} << r_start_bit);
        end else begin
            scan_mask = '1;
        end
    end

    assign free_bits = ~i_rd_data & scan_mask;
    assign free_idx  = nfid_pkg::lowest_one(free_bits);
    assign slot_bit  = nfid_pkg::WORD_W'(1) << r_slot[nfid_pkg::BIT_W-1:0];

    always_comb begin
        o_map_req         = '0;
        o_map_req.clr     = accept && (i_cmd == nfid_pkg::CMD_CLEAR);
        o_map_req.wr_en   = (r_state == S_WR);
        o_map_req.wr_addr = r_slot[nfid_pkg::SLOT_W-1:nfid_pkg::BIT_W];
        o_map_req.wr_data = r_wdata;
        if (r_state == S_SCAN) begin
            o_map_req.rd_en   = (r_rd_cnt <= nfid_pkg::CNT_W'(nfid_pkg::NUM_WORDS));
            o_map_req.rd_addr = r_rd_addr;
        end else if (r_state == S_RD) begin
            o_map_req.rd_en   = 1'b1;
            o_map_req.rd_addr = r_slot[nfid_pkg::SLOT_W-1:nfid_pkg::BIT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= nfid_pkg::BASE_RESET;
            r_last    <= nfid_pkg::SLOT_W'(nfid_pkg::NUM_IDS - 1);
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_pend <= o_map_req.rd_en;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (r_o_valid && i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_cmd;
                        r_res_id <= '0;
                        case (i_cmd)
                            nfid_pkg::CMD_ALLOC: begin
                                r_start_bit <= n_start[nfid_pkg::BIT_W-1:0];
                                r_rd_addr   <= n_start[nfid_pkg::SLOT_W-1:nfid_pkg::BIT_W];
                                r_ex_addr   <= n_start[nfid_pkg::SLOT_W-1:nfid_pkg::BIT_W];
                                r_rd_cnt    <= '0;
                                r_ex_cnt    <= '0;
                                r_state     <= S_SCAN;
                            end
                            nfid_pkg::CMD_RELEASE: begin
                                if (rel_off[nfid_pkg::ID_W-1:nfid_pkg::SLOT_W] != '0) begin
                                    r_res_status <= nfid_pkg::ST_OUT_OF_RANGE;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_slot  <= rel_off[nfid_pkg::SLOT_W-1:0];
                                    r_state <= S_RD;
                                end
                            end
                            nfid_pkg::CMD_CLEAR: begin
                                r_last       <= nfid_pkg::SLOT_W'(nfid_pkg::NUM_IDS - 1);
                                r_res_status <= nfid_pkg::ST_CLEARED;
                                r_state      <= S_OUT;
                            end
                            default: begin
                                r_res_status <= nfid_pkg::ST_OUT_OF_RANGE;
                                r_state      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (o_map_req.rd_en) begin
                        r_rd_cnt  <= r_rd_cnt + nfid_pkg::CNT_W'(1);
                        r_rd_addr <= r_rd_addr + nfid_pkg::WADDR_W'(1);
                    end
                    if (r_pend) begin
                        r_ex_cnt  <= r_ex_cnt + nfid_pkg::CNT_W'(1);
                        r_ex_addr <= r_ex_addr + nfid_pkg::WADDR_W'(1);
                        if (free_bits != '0) begin
                            r_slot  <= {r_ex_addr, free_idx};
                            r_wdata <= i_rd_data | (nfid_pkg::WORD_W'(1) << free_idx);
                            r_state <= S_WR;
                        end else if (r_ex_cnt == nfid_pkg::CNT_W'(nfid_pkg::NUM_WORDS)) begin
                            r_res_status <= nfid_pkg::ST_NONE_FREE;
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_RCHK;
                end
                S_RCHK: begin
                    if ((i_rd_data & slot_bit) != '0) begin
                        r_wdata      <= i_rd_data & ~slot_bit;
                        r_res_status <= nfid_pkg::ST_RELEASED;
                        r_state      <= S_WR;
                    end else begin
                        r_res_status <= nfid_pkg::ST_NOT_IN_USE;
                        r_state      <= S_OUT;
                    end
                end
                S_WR: begin
                    if (r_cmd == nfid_pkg::CMD_ALLOC) begin
                        r_last       <= r_slot;
                        r_res_id     <= r_base + nfid_pkg::ID_W'(r_slot);
                        r_res_status <= nfid_pkg::ST_ALLOCATED;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || i_m_axis_tready) begin
                        r_o_valid  <= 1'b1;
                        r_o_id     <= r_res_id;
                        r_o_status <= r_res_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_granted_id    = r_o_id;
    assign o_status        = r_o_status;

endmodule

// ===== src/next_fit_id_allocator_unit.sv =====
// Next-fit identifier allocator, top level.
// Channels: slave stream takes a command word (tuser = cmd, tdata = release id),
// master stream returns one result word per command (tuser = status,
// tdata = granted id). A write of i_cfg_wdata with i_cfg_we sets base_id.
// One command is in flight at a time; tready is high only while idle.
// Clear, an unused command and an out-of-range release go straight to the
// result register; release reads and checks its map word, writing it back
// when the id is in use; allocate runs a scan that reads one 64-bit map word
// per cycle, up to 65 words when the search wraps back into its starting word.
// The result sits in an output register; a new command is taken while it
// waits. If the receiver stalls, the next result is held until the output
// register empties.
// Reset: base_id 300, every identifier free, next search starts at slot 0;
// the map words are marked free through flip-flop valid bits, so no
// clearing pass is needed and the block is ready in the cycle after reset.
// Depends on nfid_pkg, nfid_map, nfid_ctrl.
module next_fit_id_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] release_id
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] granted_id
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata       // base_id
);

    nfid_pkg::t_map_req              map_req;
    logic [nfid_pkg::WORD_W-1:0]     map_rd_data;

    nfid_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (map_rd_data)
    );

    nfid_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_rel_id        (i_s_axis_tdata),
        .i_cmd           (i_s_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_map_req       (map_req),
        .i_rd_data       (map_rd_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_granted_id    (o_m_axis_tdata),
        .o_status        (o_m_axis_tuser)
    );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for next_fit_id_allocator_unit: a directed table, then random
// command mixes over several base_id settings, each result word checked
// against the table or an in-bench next-fit bitmap predictor. Uses nfid_pkg.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [nfid_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int LIMIT  = 3_000_000;
    localparam int SETTLE = 8;
    localparam int TAIL   = 80;

    typedef struct packed {
        logic [nfid_pkg::ID_W-1:0]   id;
        logic [nfid_pkg::STAT_W-1:0] st;
    } t_grant;

    typedef struct {
        bit                          wr;
        logic [nfid_pkg::CMD_W-1:0]  cmd;
        logic [nfid_pkg::ID_W-1:0]   arg;
        bit                          typed;
        logic [nfid_pkg::ID_W-1:0]   id;
        logic [nfid_pkg::STAT_W-1:0] st;
    } t_step;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;
    logic [2:0]        m_tuser;
    logic              cfg_we    = 1'b0;
    logic [15:0]       cfg_wdata = '0;

    // predictor state
    logic [nfid_pkg::NUM_IDS-1:0] slot_used       = '0;
    logic [nfid_pkg::SLOT_W-1:0]  last_grant_slot = nfid_pkg::SLOT_W'(nfid_pkg::NUM_IDS - 1);
    logic [nfid_pkg::ID_W-1:0]    base_now        = nfid_pkg::BASE_RESET;
    logic [nfid_pkg::SLOT_W-1:0]  held_slots[$];

    t_grant pending_grants[$];
    t_step  steps[$];
    int     err_cnt    = 0;
    int     cycles     = 0;
    bit     tx_gapless = 1'b0;
    bit     rx_gapless = 1'b0;

    next_fit_id_allocator_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int gap_len(input bit gapless);
        return gapless ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic void row(input bit wr, input logic [nfid_pkg::CMD_W-1:0] cmd,
                                input logic [nfid_pkg::ID_W-1:0] arg, input bit typed,
                                input logic [nfid_pkg::ID_W-1:0] id,
                                input logic [nfid_pkg::STAT_W-1:0] st);
        t_step t;
        t.wr = wr;
        t.cmd = cmd;
        t.arg = arg;
        t.typed = typed;
        t.id = id;
        t.st = st;
        steps.push_back(t);
    endfunction

    task automatic grant_for(input logic [nfid_pkg::CMD_W-1:0] cmd,
                             input logic [nfid_pkg::ID_W-1:0] rid,
                             output t_grant g);
        logic [nfid_pkg::SLOT_W-1:0] slot;
        logic [nfid_pkg::ID_W-1:0]   diff;
        bit                          found;
        int                          n;
        g.id = '0;
        found = 1'b0;
        n = 0;
        case (cmd)
            nfid_pkg::CMD_ALLOC: begin
                slot = last_grant_slot + 1'b1;
                while (!found && n < nfid_pkg::NUM_IDS) begin
                    if (!slot_used[slot]) begin
                        found = 1'b1;
                    end else begin
                        slot = slot + 1'b1;
                        n++;
                    end
                end
                if (found) begin
                    slot_used[slot] = 1'b1;
                    last_grant_slot = slot;
                    held_slots.push_back(slot);
                    g.id = base_now + nfid_pkg::ID_W'(slot);
                    g.st = nfid_pkg::ST_ALLOCATED;
                end else begin
                    g.st = nfid_pkg::ST_NONE_FREE;
                end
            end
            nfid_pkg::CMD_RELEASE: begin
                diff = rid - base_now;
                if (diff >= nfid_pkg::NUM_IDS) begin
                    g.st = nfid_pkg::ST_OUT_OF_RANGE;
                end else if (!slot_used[diff[nfid_pkg::SLOT_W-1:0]]) begin
                    g.st = nfid_pkg::ST_NOT_IN_USE;
                end else begin
                    slot_used[diff[nfid_pkg::SLOT_W-1:0]] = 1'b0;
                    for (n = 0; n < held_slots.size(); n++) begin
                        if (!found && held_slots[n] == diff[nfid_pkg::SLOT_W-1:0]) begin
                            held_slots.delete(n);
                            found = 1'b1;
                        end
                    end
                    g.st = nfid_pkg::ST_RELEASED;
                end
            end
            nfid_pkg::CMD_CLEAR: begin
                slot_used = '0;
                last_grant_slot = nfid_pkg::SLOT_W'(nfid_pkg::NUM_IDS - 1);
                held_slots.delete();
                g.st = nfid_pkg::ST_CLEARED;
            end
            default: begin
                g.st = nfid_pkg::ST_OUT_OF_RANGE;
            end
        endcase
    endtask

    task automatic send_word(input logic [nfid_pkg::CMD_W-1:0] cmd,
                             input logic [nfid_pkg::ID_W-1:0] rid,
                             input bit typed, input t_grant want);
        t_grant g;
        int     gap;
        if ($urandom_range(0, 39) == 0) tx_gapless = !tx_gapless;
        gap = gap_len(tx_gapless);
        repeat (gap) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= rid;
        s_tuser  <= cmd;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        grant_for(cmd, rid, g);
        pending_grants.push_back(typed ? want : g);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_base(input logic [nfid_pkg::ID_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        base_now = v;
    endtask

    // result side
    initial begin
        t_grant want;
        int     gap;
        forever begin
            if ($urandom_range(0, 39) == 0) rx_gapless = !rx_gapless;
            gap = gap_len(rx_gapless);
            repeat (gap) begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            if (pending_grants.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("tb_top: unexpected word id %0d status %0d", m_tdata, m_tuser);
            end else begin
                want = pending_grants.pop_front();
                if (m_tdata !== want.id || m_tuser !== want.st) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("tb_top: mismatch id exp %0d got %0d, status exp %0d got %0d",
                                 want.id, m_tdata, want.st, m_tuser);
                end
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        t_grant                      want;
        logic [nfid_pkg::ID_W-1:0]   rid;
        logic [nfid_pkg::ID_W-1:0]   pbase;
        logic [nfid_pkg::CMD_W-1:0]  cmd;
        int                          r;
        int                          idx;

        // base 300 after reset
        row(0, nfid_pkg::CMD_ALLOC,   16'h0000, 1, 16'd300, nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_ALLOC,   16'hFFFF, 1, 16'd301, nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_RELEASE, 16'd300,  1, 16'd0,   nfid_pkg::ST_RELEASED);
        row(0, nfid_pkg::CMD_RELEASE, 16'd300,  1, 16'd0,   nfid_pkg::ST_NOT_IN_USE);
        row(0, nfid_pkg::CMD_RELEASE, 16'd299,  1, 16'd0,   nfid_pkg::ST_OUT_OF_RANGE);
        row(0, nfid_pkg::CMD_RELEASE, 16'd4395, 1, 16'd0,   nfid_pkg::ST_NOT_IN_USE);
        row(0, nfid_pkg::CMD_RELEASE, 16'd4396, 1, 16'd0,   nfid_pkg::ST_OUT_OF_RANGE);
        row(0, nfid_pkg::CMD_RELEASE, 16'hFFFF, 1, 16'd0,   nfid_pkg::ST_OUT_OF_RANGE);
        row(0, nfid_pkg::CMD_RELEASE, 16'h0000, 1, 16'd0,   nfid_pkg::ST_OUT_OF_RANGE);
        row(0, CMD_UNUSED,            16'hFFFF, 1, 16'd0,   nfid_pkg::ST_OUT_OF_RANGE);
        row(0, nfid_pkg::CMD_ALLOC,   16'h0000, 1, 16'd302, nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_CLEAR,   16'hFFFF, 1, 16'd0,   nfid_pkg::ST_CLEARED);
        row(0, nfid_pkg::CMD_ALLOC,   16'h0000, 1, 16'd300, nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_RELEASE, 16'd301,  1, 16'd0,   nfid_pkg::ST_NOT_IN_USE);
        // base 0
        row(1, CMD_UNUSED,            16'h0000, 0, 16'd0,   nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_ALLOC,   16'h0000, 0, 16'd0,   nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_RELEASE, 16'h0000, 0, 16'd0,   nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_RELEASE, 16'd4096, 0, 16'd0,   nfid_pkg::ST_ALLOCATED);
        // base at top of range, ids wrap through zero
        row(1, CMD_UNUSED,            16'hFFFF, 0, 16'd0,   nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_CLEAR,   16'h0000, 1, 16'd0,   nfid_pkg::ST_CLEARED);
        row(0, nfid_pkg::CMD_ALLOC,   16'h0000, 1, 16'hFFFF, nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_ALLOC,   16'h0000, 1, 16'd0,   nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_ALLOC,   16'h0000, 1, 16'd1,   nfid_pkg::ST_ALLOCATED);
        row(0, nfid_pkg::CMD_RELEASE, 16'h0000, 1, 16'd0,   nfid_pkg::ST_RELEASED);
        row(0, nfid_pkg::CMD_RELEASE, 16'hFFFE, 1, 16'd0,   nfid_pkg::ST_OUT_OF_RANGE);
        row(0, nfid_pkg::CMD_RELEASE, 16'h0000, 1, 16'd0,   nfid_pkg::ST_NOT_IN_USE);
        row(0, CMD_UNUSED,            16'h0000, 1, 16'd0,   nfid_pkg::ST_OUT_OF_RANGE);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (steps[i]) begin
            if (steps[i].wr) begin
                write_base(steps[i].arg);
            end else begin
                want.id = steps[i].id;
                want.st = steps[i].st;
                send_word(steps[i].cmd, steps[i].arg, steps[i].typed, want);
            end
        end

        want = '0;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: pbase = 16'h0000;
                1: pbase = 16'hF000;
                2: pbase = 16'hFFFF;
                3: pbase = 16'($urandom_range(0, 61440));
                4: pbase = 16'($urandom);
                default: pbase = nfid_pkg::BASE_RESET;
            endcase
            write_base(pbase);
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(0, 99) == 0 || (p == 0 && n == 75)) drain();
                r = $urandom_range(0, 99);
                rid = 16'($urandom);
                if (r < 50 || (r < 78 && held_slots.size() == 0)) begin
                    cmd = nfid_pkg::CMD_ALLOC;
                end else if (r < 78) begin
                    cmd = nfid_pkg::CMD_RELEASE;
                    idx = $urandom_range(0, held_slots.size() - 1);
                    rid = base_now + nfid_pkg::ID_W'(held_slots[idx]);
                end else if (r < 88) begin
                    cmd = nfid_pkg::CMD_RELEASE;
                    rid = base_now + 16'($urandom_range(0, nfid_pkg::NUM_IDS - 1));
                end else if (r < 91) begin
                    cmd = nfid_pkg::CMD_RELEASE;
                    rid = $urandom_range(0, 1) ? base_now - 16'd1
                        : base_now + 16'(nfid_pkg::NUM_IDS + $urandom_range(0, 3));
                end else if (r < 94) begin
                    cmd = nfid_pkg::CMD_RELEASE;
                end else if (r < 97) begin
                    cmd = nfid_pkg::CMD_CLEAR;
                end else begin
                    cmd = CMD_UNUSED;
                end
                send_word(cmd, rid, 0, want);
            end
        end

        drain();
        repeat (TAIL) @(posedge clk);
        if (err_cnt == 0 && pending_grants.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
